/* rtl/dss_pkg.sv */
// Package for the dual stack block: operation and status codes, controller
// states, and the command/status structs that join controller and datapath.
// No dependencies.
`timescale 1ns / 1ps

package dss_pkg;

  // Operation codes of an input item
  typedef enum logic [1:0] {
    OP_PUSH = 2'd0,
    OP_POP  = 2'd1,
    OP_SHOW = 2'd2
  } op_e;

  // Status codes of a result item
  typedef enum logic [2:0] {
    STAT_DONE      = 3'd0,
    STAT_OVERFLOW  = 3'd1,
    STAT_UNDERFLOW = 3'd2,
    STAT_ELEMENT   = 3'd3,
    STAT_EMPTY     = 3'd4
  } status_e;

  // Kind of result the datapath loads into the output register
  typedef enum logic [1:0] {
    KIND_PUSH,
    KIND_POP,
    KIND_ELEM,
    KIND_EMPTY
  } kind_e;

  // Read address selection for the display walk
  typedef enum logic [1:0] {
    RD_HOLD,
    RD_NEXT,
    RD_LO_BASE,
    RD_HI_BASE
  } rd_sel_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SHOW_LO,
    ST_SHOW_HI
  } state_e;

  typedef struct packed {
    logic    load;
    kind_e   kind;
    logic    which;
    logic    last;
    rd_sel_e rd_sel;
  } dss_cmd_t;

  typedef struct packed {
    logic out_free;
    logic lo_empty;
    logic hi_empty;
    logic lo_last;
    logic hi_last;
  } dss_stat_t;

endpackage

/* rtl/dual_stack_shared_array.sv */
// Top level of the dual stack block: two stacks sharing one memory.
// Instantiates dss_ctrl and dss_dpath; uses dss_pkg.
`timescale 1ns / 1ps

// Two stacks share one memory of DEPTH 32-bit entries: the lower stack grows
// up from entry 0, the upper stack down from entry DEPTH-1. A push reports
// overflow once the two stacks together fill the memory, whichever stack is
// chosen; a pop drops the top entry (no value returned) or reports underflow
// on an empty stack. A display sends every lower entry bottom to top, then
// every upper entry bottom to top, with an empty marker in place of an empty
// stack, and flags its final result with last. Push and pop each give one
// result. A display first primes the memory read port and then gives its
// results one at a time (DEPTH + 1 at most), paced by the single registered
// read port of the memory; no new item is accepted until the last result of
// a display is loaded into the output register.
// Results leave from a single output register, and an item is accepted only
// while that register is empty or being taken in the same cycle, so a result
// that waits downstream holds off the input. Unused operation codes are
// accepted and give no result. No clearing pass follows reset.

module dual_stack_shared_array
  import dss_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic               stack_select_i,
  input  logic signed [31:0] push_value_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic               which_stack_o,
  output logic signed [31:0] element_value_o,
  output logic               last_o
);

  dss_cmd_t  cmd;
  dss_stat_t stat;

  // Sequence item acceptance and the display walk
  dss_ctrl u_ctrl (
    .clk_i                     (clk_i),
    .rst_ni                    (rst_ni),
    .in_valid_i                (in_valid_i),
    .in_stall_o_unused_guard_i (1'b0),
    .operation_i               (operation_i),
    .stack_select_i            (stack_select_i),
    .stat_i                    (stat),
    .in_stall_o                (in_stall_o),
    .cmd_o                     (cmd)
  );

  // Hold counters, memory and the output register
  dss_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .push_value_i    (push_value_i),
    .out_stall_i     (out_stall_i),
    .stat_o          (stat),
    .out_valid_o     (out_valid_o),
    .status_o        (status_o),
    .which_stack_o   (which_stack_o),
    .element_value_o (element_value_o),
    .last_o          (last_o)
  );

endmodule

/* rtl/dss_ctrl.sv */
// Controller for the dual stack block: accepts items and sequences the
// display walk. Depends on dss_pkg; drives dss_dpath through dss_cmd_t.
`timescale 1ns / 1ps

module dss_ctrl
  import dss_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_stall_o_unused_guard_i,
  input  logic [1:0] operation_i,
  input  logic      stack_select_i,
  input  dss_stat_t stat_i,
  output logic      in_stall_o,
  output dss_cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    in_stall_o    = 1'b1;
    cmd_o.load    = 1'b0;
    cmd_o.kind    = KIND_ELEM;
    cmd_o.which   = 1'b0;
    cmd_o.last    = 1'b0;
    cmd_o.rd_sel  = RD_HOLD;
    unique case (state_q)
      ST_IDLE: begin
        in_stall_o = !stat_i.out_free || in_stall_o_unused_guard_i;
        if (in_valid_i && !in_stall_o) begin
          unique case (op_e'(operation_i))
            OP_PUSH: begin
              cmd_o.load  = 1'b1;
              cmd_o.kind  = KIND_PUSH;
              cmd_o.which = stack_select_i;
              cmd_o.last  = 1'b1;
            end
            OP_POP: begin
              cmd_o.load  = 1'b1;
              cmd_o.kind  = KIND_POP;
              cmd_o.which = stack_select_i;
              cmd_o.last  = 1'b1;
            end
            OP_SHOW: begin
              cmd_o.rd_sel = RD_LO_BASE;
              state_d      = ST_SHOW_LO;
            end
            default: begin
              // drop unused codes
            end
          endcase
        end
      end
      ST_SHOW_LO: begin
        cmd_o.which = 1'b0;
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          if (stat_i.lo_empty) begin
            cmd_o.kind   = KIND_EMPTY;
            cmd_o.rd_sel = RD_HI_BASE;
            state_d      = ST_SHOW_HI;
          end else if (stat_i.lo_last) begin
            cmd_o.rd_sel = RD_HI_BASE;
            state_d      = ST_SHOW_HI;
          end else begin
            cmd_o.rd_sel = RD_NEXT;
          end
        end
      end
      ST_SHOW_HI: begin
        cmd_o.which = 1'b1;
        if (stat_i.out_free) begin
          cmd_o.load = 1'b1;
          if (stat_i.hi_empty) begin
            cmd_o.kind = KIND_EMPTY;
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end else if (stat_i.hi_last) begin
            cmd_o.last = 1'b1;
            state_d    = ST_IDLE;
          end else begin
            cmd_o.rd_sel = RD_NEXT;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/dss_dpath.sv */
// Datapath for the dual stack block: stack counters, shared memory with a
// registered read port, display index and the output register. Uses dss_pkg.
`timescale 1ns / 1ps

module dss_dpath
  import dss_pkg::*;
#(
  parameter int DEPTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dss_cmd_t           cmd_i,
  input  logic signed [31:0] push_value_i,
  input  logic               out_stall_i,
  output dss_stat_t          stat_o,
  output logic               out_valid_o,
  output logic [2:0]         status_o,
  output logic               which_stack_o,
  output logic signed [31:0] element_value_o,
  output logic               last_o
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] TopAddr = AW'(DEPTH - 1);
  localparam logic [CW:0]   DepthSum = (CW + 1)'(DEPTH);

  logic [31:0]   mem_q [DEPTH];
  logic [31:0]   rdata_q;
  logic [CW-1:0] lo_cnt_q, lo_cnt_d;
  logic [CW-1:0] hi_cnt_q, hi_cnt_d;
  logic [CW-1:0] idx_q, idx_d;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] rd_idx;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic          full;
  logic          sel_empty;
  logic          push_ok;
  logic          out_taken;

  logic          ovalid_q;
  status_e       ostat_q, ostat_d;
  logic          owhich_q;
  logic [31:0]   oval_q, oval_d;
  logic          olast_q;

  assign full      = ({1'b0, lo_cnt_q} + {1'b0, hi_cnt_q}) >= DepthSum;
  assign sel_empty = cmd_i.which ? (hi_cnt_q == '0) : (lo_cnt_q == '0);
  assign push_ok   = cmd_i.load && (cmd_i.kind == KIND_PUSH) && !full;
  assign out_taken = ovalid_q && !out_stall_i;
  assign idx_inc   = idx_q + CW'(1);

  assign stat_o.out_free = !ovalid_q || !out_stall_i;
  assign stat_o.lo_empty = (lo_cnt_q == '0);
  assign stat_o.hi_empty = (hi_cnt_q == '0);
  assign stat_o.lo_last  = (idx_inc == lo_cnt_q);
  assign stat_o.hi_last  = (idx_inc == hi_cnt_q);

  // Read address: prefetch the entry the walk emits next
  always_comb begin
    idx_d  = idx_q;
    rd_idx = idx_q;
    case (cmd_i.rd_sel)
      RD_NEXT: begin
        idx_d  = idx_inc;
        rd_idx = idx_inc;
      end
      RD_LO_BASE, RD_HI_BASE: begin
        idx_d  = '0;
        rd_idx = '0;
      end
      default: begin
      end
    endcase
    if (cmd_i.rd_sel == RD_HI_BASE || (cmd_i.rd_sel != RD_LO_BASE && cmd_i.which)) begin
      raddr = TopAddr - rd_idx[AW-1:0];
    end else begin
      raddr = rd_idx[AW-1:0];
    end
  end

  assign waddr = cmd_i.which ? (TopAddr - hi_cnt_q[AW-1:0]) : lo_cnt_q[AW-1:0];

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[waddr] <= push_value_i;
    end
    rdata_q <= mem_q[raddr];
  end

  // Counter updates for push and pop
  always_comb begin
    lo_cnt_d = lo_cnt_q;
    hi_cnt_d = hi_cnt_q;
    if (push_ok) begin
      if (cmd_i.which) hi_cnt_d = hi_cnt_q + CW'(1);
      else             lo_cnt_d = lo_cnt_q + CW'(1);
    end else if (cmd_i.load && cmd_i.kind == KIND_POP && !sel_empty) begin
      if (cmd_i.which) hi_cnt_d = hi_cnt_q - CW'(1);
      else             lo_cnt_d = lo_cnt_q - CW'(1);
    end
  end

  // Result payload
  always_comb begin
    oval_d = '0;
    case (cmd_i.kind)
      KIND_PUSH:  ostat_d = full ? STAT_OVERFLOW : STAT_DONE;
      KIND_POP:   ostat_d = sel_empty ? STAT_UNDERFLOW : STAT_DONE;
      KIND_ELEM: begin
        ostat_d = STAT_ELEMENT;
        oval_d  = rdata_q;
      end
      default:    ostat_d = STAT_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lo_cnt_q <= '0;
      hi_cnt_q <= '0;
      idx_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      lo_cnt_q <= lo_cnt_d;
      hi_cnt_q <= hi_cnt_d;
      idx_q    <= idx_d;
      if (cmd_i.load) begin
        ovalid_q <= 1'b1;
      end else if (out_taken) begin
        ovalid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ostat_q  <= ostat_d;
      owhich_q <= cmd_i.which;
      oval_q   <= oval_d;
      olast_q  <= cmd_i.last;
    end
  end

  assign out_valid_o     = ovalid_q;
  assign status_o        = ostat_q;
  assign which_stack_o   = owhich_q;
  assign element_value_o = oval_q;
  assign last_o          = olast_q;

  // The two stacks never hold more entries than the memory has
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, lo_cnt_q} + {1'b0, hi_cnt_q}) <= DepthSum)
    else $error("stack counts exceed memory depth");

  // A pending result is never overwritten before it is taken
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && ovalid_q |-> !out_stall_i)
    else $error("output register overwritten while stalled");

  // An element is only emitted from inside the stack being walked
  a_elem_in_stack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load && cmd_i.kind == KIND_ELEM |->
      (cmd_i.which ? (idx_q < hi_cnt_q) : (idx_q < lo_cnt_q)))
    else $error("element read outside its stack");

endmodule

/* dv/tb_dual_stack_shared_array.sv */
// Self-checking testbench for dual_stack_shared_array: push, pop and display
// items against a cycle-free shadow of both stacks, with random idling.
// Depends on dss_pkg and the dual_stack_shared_array RTL.
`timescale 1ns / 1ps

module tb_dual_stack_shared_array;
  import dss_pkg::*;

  localparam int DEPTH = 32;
  // Operation code outside the defined set: accepted, gives no result
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int ITEM_TARGET = 410;
  localparam int MAX_REPORTS = 10;

  // One result item as the block should emit it
  typedef struct {
    status_e     status;
    logic        which;
    logic [31:0] value;
    logic        last;
  } stack_result_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [1:0]         operation_i;
  logic               stack_select_i;
  logic signed [31:0] push_value_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [2:0]         status_o;
  logic               which_stack_o;
  logic signed [31:0] element_value_o;
  logic               last_o;

  // Shadow of the block: shared entries and the fill level of each stack
  logic [31:0]   shadow_mem [DEPTH];
  int            lower_depth;
  int            upper_depth;
  stack_result_t pending_results[$];

  int mismatch_count;
  int items_sent;
  // While set, the matching side never idles
  bit tx_calm;
  bit rx_calm;

  dual_stack_shared_array #(
    .DEPTH(DEPTH)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .stack_select_i (stack_select_i),
    .push_value_i   (push_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .which_stack_o  (which_stack_o),
    .element_value_o(element_value_o),
    .last_o         (last_o)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Generous fixed limit: far above the slowest legal run
  initial begin
    #20_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // Length of one idle stretch: mostly short, a few long
  function automatic int idle_length();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 75) return $urandom_range(1, 2);
    if (roll < 95) return $urandom_range(3, 8);
    return $urandom_range(20, 40);
  endfunction

  // Push data: extremes and sign boundaries often, plain random otherwise
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      4: return $urandom_range(0, 255);
      default: return $urandom;
    endcase
  endfunction

  function automatic stack_result_t make_result(status_e st, logic sel, logic [31:0] val,
                                                logic fin);
    stack_result_t r;
    r.status = st;
    r.which  = sel;
    r.value  = val;
    r.last   = fin;
    return r;
  endfunction

  // Apply one accepted item to the shadow and queue the results it causes
  task automatic predict_stack_results(input logic [1:0] op, input logic sel,
                                       input logic [31:0] val);
    case (op)
      OP_PUSH: begin
        // Overflow is judged on the shared fill, whichever stack is chosen
        if (lower_depth + upper_depth >= DEPTH) begin
          pending_results.push_back(make_result(STAT_OVERFLOW, sel, '0, 1'b1));
        end else begin
          if (sel == 1'b0) begin
            shadow_mem[lower_depth] = val;
            lower_depth++;
          end else begin
            shadow_mem[DEPTH - 1 - upper_depth] = val;
            upper_depth++;
          end
          pending_results.push_back(make_result(STAT_DONE, sel, '0, 1'b1));
        end
      end
      OP_POP: begin
        if ((sel ? upper_depth : lower_depth) == 0) begin
          pending_results.push_back(make_result(STAT_UNDERFLOW, sel, '0, 1'b1));
        end else begin
          if (sel) upper_depth--;
          else lower_depth--;
          pending_results.push_back(make_result(STAT_DONE, sel, '0, 1'b1));
        end
      end
      OP_SHOW: begin
        // Lower stack never carries last: the upper part always follows
        if (lower_depth == 0) begin
          pending_results.push_back(make_result(STAT_EMPTY, 1'b0, '0, 1'b0));
        end
        for (int i = 0; i < lower_depth; i++) begin
          pending_results.push_back(make_result(STAT_ELEMENT, 1'b0, shadow_mem[i], 1'b0));
        end
        if (upper_depth == 0) begin
          pending_results.push_back(make_result(STAT_EMPTY, 1'b1, '0, 1'b1));
        end
        for (int i = 0; i < upper_depth; i++) begin
          pending_results.push_back(make_result(STAT_ELEMENT, 1'b1,
                                                shadow_mem[DEPTH - 1 - i],
                                                i == upper_depth - 1));
        end
      end
      default: ;
    endcase
  endtask

  // Drive one item at the clock edge and hold it until the block takes it.
  // Valid stays high across back-to-back items; it only drops for a gap.
  task automatic send_item(input logic [1:0] op, input logic sel, input logic [31:0] val);
    int gap;
    gap = (tx_calm || $urandom_range(0, 99) < 55) ? 0 : idle_length();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    operation_i    <= op;
    stack_select_i <= sel;
    push_value_i   <= val;
    predict_stack_results(op, sel, val);
    items_sent++;
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, field, exp_v, act_v);
    end
  endtask

  // Check every accepted result against the oldest expectation, then pick
  // the stall for the next edge.
  always @(posedge clk_i) begin : check_results
    stack_result_t exp_r;
    int            stall_left;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, status", '0, status_o);
      end else begin
        exp_r = pending_results.pop_front();
        if (status_o != exp_r.status) note_mismatch("status", exp_r.status, status_o);
        if (which_stack_o != exp_r.which) note_mismatch("which_stack", exp_r.which,
                                                        which_stack_o);
        if (element_value_o != exp_r.value) note_mismatch("element_value", exp_r.value,
                                                          element_value_o);
        if (last_o != exp_r.last) note_mismatch("last", exp_r.last, last_o);
      end
    end
    if (rx_calm) begin
      stall_left = 0;
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 99) < 25) begin
      stall_left = idle_length() - 1;
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // Empty stacks: empty markers on display, underflow on both, unused code
  task automatic test_empty_stacks();
    send_item(OP_SHOW, 1'b0, 32'h0);
    send_item(OP_POP, 1'b0, 32'h0);
    send_item(OP_POP, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_UNUSED, 1'b1, 32'h1234_5678);
    send_item(OP_SHOW, 1'b1, 32'hFFFF_FFFF);
  endtask

  // Extreme values through both stacks, with pops down to underflow
  task automatic test_value_extremes();
    send_item(OP_PUSH, 1'b0, 32'h8000_0000);
    send_item(OP_PUSH, 1'b0, 32'h7FFF_FFFF);
    send_item(OP_PUSH, 1'b1, 32'h0000_0000);
    send_item(OP_PUSH, 1'b1, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 1'b1, 32'h0000_0001);
    send_item(OP_SHOW, 1'b0, 32'h0);
    send_item(OP_POP, 1'b0, 32'h0);
    send_item(OP_POP, 1'b1, 32'h0);
    send_item(OP_SHOW, 1'b1, 32'h0);
    send_item(OP_POP, 1'b0, 32'h0);
    send_item(OP_POP, 1'b0, 32'h0);
    send_item(OP_POP, 1'b1, 32'h0);
    send_item(OP_POP, 1'b1, 32'h0);
    send_item(OP_POP, 1'b1, 32'h0);
    send_item(OP_SHOW, 1'b0, 32'h0);
  endtask

  // Fill the memory through the chosen stacks, hit overflow from both
  // sides, show the full memory, then drain both stacks past empty.
  // fill_mode: 0 lower only, 1 upper only, 2 random mix.
  task automatic test_full_and_drain(input int fill_mode);
    logic sel;
    while (lower_depth + upper_depth < DEPTH) begin
      sel = (fill_mode == 2) ? 1'($urandom_range(0, 1)) : 1'(fill_mode);
      send_item(OP_PUSH, sel, pick_value());
    end
    send_item(OP_PUSH, 1'b0, pick_value());
    send_item(OP_PUSH, 1'b1, pick_value());
    send_item(OP_SHOW, 1'($urandom_range(0, 1)), pick_value());
    while (lower_depth + upper_depth > 0) begin
      sel = (lower_depth == 0) ? 1'b1 : (upper_depth == 0) ? 1'b0 : 1'($urandom_range(0, 1));
      send_item(OP_POP, sel, pick_value());
    end
    send_item(OP_POP, 1'b0, pick_value());
    send_item(OP_POP, 1'b1, pick_value());
    send_item(OP_SHOW, 1'b0, pick_value());
  endtask

  // Random bursts: fill-heavy, drain-heavy, balanced and noisy stretches,
  // each with its own idling mood, until the item budget is spent.
  task automatic test_random_mix();
    int         burst_kind;
    int         burst_len;
    int         roll;
    int         push_pct;
    logic [1:0] op;
    while (items_sent < ITEM_TARGET) begin
      burst_kind = $urandom_range(0, 9);
      burst_len  = $urandom_range(5, 30);
      tx_calm    = ($urandom_range(0, 4) == 0);
      rx_calm    = ($urandom_range(0, 4) == 0);
      push_pct   = (burst_kind < 4) ? 85 : (burst_kind < 7) ? 15 : 50;
      repeat (burst_len) begin
        roll = $urandom_range(0, 99);
        if (burst_kind == 9) begin
          // Noise: unused codes and displays among random ops
          op = 2'($urandom_range(0, 3));
        end else if (roll < 7) begin
          op = OP_SHOW;
        end else if (roll < 8) begin
          op = OP_UNUSED;
        end else begin
          op = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
        end
        send_item(op, 1'($urandom_range(0, 1)), pick_value());
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  // Drop valid right after the last accepted item, let every expected
  // result arrive, then watch a quiet tail for strays
  task automatic finish_run();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    operation_i    = OP_PUSH;
    stack_select_i = 1'b0;
    push_value_i   = '0;
    out_stall_i    = 1'b0;
    lower_depth    = 0;
    upper_depth    = 0;
    mismatch_count = 0;
    items_sent     = 0;
    tx_calm        = 1'b0;
    rx_calm        = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_stacks();
    test_value_extremes();
    test_full_and_drain(0);
    test_full_and_drain(1);
    test_full_and_drain(2);
    test_random_mix();
    finish_run();

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/dss_pkg.sv
rtl/dss_ctrl.sv
rtl/dss_dpath.sv
rtl/dual_stack_shared_array.sv
dv/tb_dual_stack_shared_array.sv
